@@ rtl/mme_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Request and result payloads, pipeline tags and the action codes.
// ----------------------------------------------------------------------------
package mme_pkg;

    // Action codes of an input request.
    localparam logic [1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ROWS_OF_A    = 2'd0;
    localparam logic [1:0] CFG_INNER_LENGTH = 2'd1;
    localparam logic [1:0] CFG_COLS_OF_B    = 2'd2;

    // Reset value of every dimension register.
    localparam logic [3:0] DIM_RESET = 4'd8;

    // Depth of the request queue between front and back.
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         elem_row;
        logic [2:0]         elem_col;
        logic signed [15:0] elem_value;
    } t_in_req;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [39:0] out_value;
        logic               last_flag;
    } t_out_res;

    // Last valid index of each dimension (effective dimension minus one).
    typedef struct packed {
        logic [3:0] rows_last;
        logic [3:0] inner_last;
        logic [3:0] cols_last;
    } t_dims;

    // Tag that travels with one product down the multiply-accumulate pipe.
    typedef struct packed {
        logic       first;
        logic       last_k;
        logic       last_elem;
        logic [2:0] row;
        logic [2:0] col;
    } t_tag;

endpackage
`default_nettype wire

@@ rtl/matrix_multiply_engine_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core: C = A x B over signed Q8.8 elements
// Top level: request intake, request queue and the compute back end.
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low. Load requests
// write one element of A or B in the back end; a compute request emits
// every element of C in row-major order, one result per o_res_valid
// strobe, the last one flagged. A compute request over M rows, inner
// length N and P columns is taken from the queue and then issues its
// M*P*N products one per cycle from the single multiply-accumulate unit
// fed by one read port of each store. A four-entry queue lies between
// intake and back end, and o_busy is high while it is full. Results
// cannot be held off: each is valid for exactly one cycle. Dimension
// registers are written through the configuration port; the user must
// write them only while no request is in flight, as the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_core
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_in_req    i_req,
    output logic            o_busy,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [3:0] i_cfg_data,
    output logic            o_res_valid,
    output t_out_res        o_res
);

    logic    w_push;
    t_in_req w_push_data;
    logic    w_pop;
    t_in_req w_head;
    logic    w_full;
    logic    w_empty;
    t_dims   w_dims;

    // Intake and configuration.
    mme_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .o_busy      (o_busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .o_dims      (w_dims)
    );

    // Request queue between intake and back end.
    mme_queue #(
        .WIDTH ($bits(t_in_req)),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_full      (w_full),
        .o_empty     (w_empty)
    );

    // Store writes and the multiply-accumulate sequencer.
    mme_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .i_dims      (w_dims),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
`default_nettype wire

@@ rtl/mme_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mme_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/mme_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mme_queue: short request queue
// Flip-flop FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module mme_queue #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_head,
    output logic                  o_full,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_entry [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_head  = r_entry[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule
`default_nettype wire

@@ rtl/mme_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mme_front: request intake and configuration
// Holds the dimension registers, accepts requests and drops those that
// have no effect before they reach the queue.
// ----------------------------------------------------------------------------
module mme_front
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_in_req    i_req,
    output logic            o_busy,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [3:0] i_cfg_data,
    input  wire logic       i_full,
    output logic            o_push,
    output t_in_req         o_push_data,
    output t_dims           o_dims
);

    logic [3:0] r_rows_of_a;
    logic [3:0] r_inner_length;
    logic [3:0] r_cols_of_b;
    logic       w_keep;
    logic       w_in_range;

    // Dimension registers; writes to an unused index are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_of_a    <= DIM_RESET;
            r_inner_length <= DIM_RESET;
            r_cols_of_b    <= DIM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ROWS_OF_A:    r_rows_of_a    <= i_cfg_data;
                CFG_INNER_LENGTH: r_inner_length <= i_cfg_data;
                CFG_COLS_OF_B:    r_cols_of_b    <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // A zero dimension acts as one, any above the store size as the maximum.
    function automatic logic [3:0] last_index(input logic [3:0] dim);
        logic [3:0] res;
        if (dim == 4'd0) begin
            res = 4'd0;
        end else if (32'(dim) > MAX_DIM) begin
            res = 4'(MAX_DIM - 1);
        end else begin
            res = dim - 4'd1;
        end
        return res;
    endfunction

    assign o_dims.rows_last  = last_index(r_rows_of_a);
    assign o_dims.inner_last = last_index(r_inner_length);
    assign o_dims.cols_last  = last_index(r_cols_of_b);

    // Classify: loads inside the store and compute requests go on; the
    // unused action code and out-of-range loads are dropped here.
    assign w_in_range = (32'(i_req.elem_row) < MAX_DIM) && (32'(i_req.elem_col) < MAX_DIM);

    always_comb begin
        case (i_req.action)
            ACT_LOAD_A, ACT_LOAD_B: w_keep = w_in_range;
            ACT_COMPUTE:            w_keep = 1'b1;
            default:                w_keep = 1'b0;
        endcase
    end

    assign o_busy      = i_full;
    assign o_push      = i_start && !i_full && w_keep;
    assign o_push_data = i_req;

endmodule
`default_nettype wire

@@ rtl/mme_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mme_back: store writes and the multiply-accumulate sequencer
// Pops requests, writes loads into the A and B stores and walks a compute
// request through one shared multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module mme_back
    import mme_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_in_req i_head,
    input  wire logic    i_empty,
    input  wire t_dims   i_dims,
    output logic         o_pop,
    output logic         o_res_valid,
    output t_out_res     o_res
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              r_state, n_state;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_k, n_k;
    t_dims             r_dims;

    logic              w_issue;
    logic              w_k_end;
    logic              w_j_end;
    logic              w_i_end;
    t_tag              w_tag;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_a_raddr;
    logic [ADDR_W-1:0] w_b_raddr;
    logic              w_we_a;
    logic              w_we_b;
    logic [15:0]       w_a_rdata;
    logic [15:0]       w_b_rdata;

    logic               r_s1_valid;
    t_tag               r_s1_tag;
    logic               r_s2_valid;
    t_tag               r_s2_tag;
    logic signed [31:0] r_prod;
    logic signed [39:0] r_acc, n_acc;
    logic               r_res_valid;
    t_out_res           r_res;

    // Requests are taken only between compute runs.
    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign w_we_a  = o_pop && (i_head.action == ACT_LOAD_A);
    assign w_we_b  = o_pop && (i_head.action == ACT_LOAD_B);
    assign w_waddr = ADDR_W'(32'(i_head.elem_row) * MAX_DIM + 32'(i_head.elem_col));

    // Loop bounds of the element walk.
    assign w_issue = (r_state == ST_RUN);
    assign w_k_end = (r_k == CNT_W'(r_dims.inner_last));
    assign w_j_end = (r_j == CNT_W'(r_dims.cols_last));
    assign w_i_end = (r_i == CNT_W'(r_dims.rows_last));

    // Sequencer: one product per cycle, k innermost, then columns, then rows.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            ST_IDLE: begin
                if (o_pop && (i_head.action == ACT_COMPUTE)) begin
                    n_state = ST_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            ST_RUN: begin
                if (!w_k_end) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_k = '0;
                    if (!w_j_end) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_j = '0;
                        if (w_i_end) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_i = r_i + 1'b1;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    // Dimensions are sampled when a compute run starts.
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head.action == ACT_COMPUTE)) begin
            r_dims <= i_dims;
        end
    end

    // Read addresses and the tag of the product being issued.
    assign w_a_raddr = ADDR_W'(32'(r_i) * MAX_DIM + 32'(r_k));
    assign w_b_raddr = ADDR_W'(32'(r_k) * MAX_DIM + 32'(r_j));

    assign w_tag.first     = (r_k == '0);
    assign w_tag.last_k    = w_k_end;
    assign w_tag.last_elem = w_k_end && w_j_end && w_i_end;
    assign w_tag.row       = 3'(r_i);
    assign w_tag.col       = 3'(r_j);

    mme_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_head.elem_value),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    mme_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_head.elem_value),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // Accumulate: the first product of an element restarts the sum.
    always_comb begin
        if (r_s2_tag.first) begin
            n_acc = 40'(r_prod);
        end else begin
            n_acc = r_acc + 40'(r_prod);
        end
    end

    // Pipeline valid bits and the accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_acc       <= '0;
        end else begin
            r_s1_valid  <= w_issue;
            r_s2_valid  <= r_s1_valid;
            r_res_valid <= r_s2_valid && r_s2_tag.last_k;
            if (r_s2_valid) begin
                r_acc <= n_acc;
            end
        end
    end

    // Pipeline payload: tags, product and the result register.
    always_ff @(posedge i_clk) begin
        r_s1_tag <= w_tag;
        r_s2_tag <= r_s1_tag;
        r_prod   <= $signed(w_a_rdata) * $signed(w_b_rdata);
        if (r_s2_valid && r_s2_tag.last_k) begin
            r_res.out_row   <= r_s2_tag.row;
            r_res.out_col   <= r_s2_tag.col;
            r_res.out_value <= n_acc;
            r_res.last_flag <= r_s2_tag.last_elem;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // A result follows only the last product of an element.
    a_res_after_last_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> $past(r_s2_valid && r_s2_tag.last_k))
        else $error("result without a completed dot product");

    // No request is taken while a compute run issues products.
    a_no_pop_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !o_pop)
        else $error("request popped during a compute run");

    // A run that issued its final product returns to idle.
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_tag.last_elem) |=> (r_state == ST_IDLE))
        else $error("compute run did not end after its last product");

    // Store writes never happen during a compute run.
    a_no_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> !(w_we_a || w_we_b))
        else $error("store write during a compute run");

endmodule
`default_nettype wire
